### src/etc_pkg.sv
`default_nettype none

package etc_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int STEP_W = 5;

	// divider operand selection
	localparam logic [1:0] DIV_NONE     = 2'd0;
	localparam logic [1:0] DIV_REST_P   = 2'd1;
	localparam logic [1:0] DIV_ACC_P    = 2'd2;
	localparam logic [1:0] DIV_ACC_REST = 2'd3;

	// register operations
	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_LOAD    = 3'd1;
	localparam logic [2:0] OP_REST_Q  = 3'd2;
	localparam logic [2:0] OP_ACC_SUB = 3'd3;
	localparam logic [2:0] OP_P_INC   = 3'd4;
	localparam logic [2:0] OP_ACC_ONE = 3'd5;
	localparam logic [2:0] OP_OUT     = 3'd6;

	// jump conditions; taken goes to target, otherwise to the next step
	localparam logic [3:0] C_NEXT     = 4'd0;
	localparam logic [3:0] C_ALWAYS   = 4'd1;
	localparam logic [3:0] C_NO_VALID = 4'd2;
	localparam logic [3:0] C_REST_LT2 = 4'd3;
	localparam logic [3:0] C_BUSY     = 4'd4;
	localparam logic [3:0] C_Q_LT_P   = 4'd5;
	localparam logic [3:0] C_R_NZ     = 4'd6;
	localparam logic [3:0] C_R_Z      = 4'd7;
	localparam logic [3:0] C_OUT_FULL = 4'd8;

	// program addresses
	localparam logic [STEP_W-1:0] S_OUT    = 5'd0;
	localparam logic [STEP_W-1:0] S_IDLE   = 5'd1;
	localparam logic [STEP_W-1:0] S_CHECK  = 5'd2;
	localparam logic [STEP_W-1:0] S_TRY    = 5'd3;
	localparam logic [STEP_W-1:0] S_TRY_W  = 5'd4;
	localparam logic [STEP_W-1:0] S_TEST_Q = 5'd5;
	localparam logic [STEP_W-1:0] S_TEST_R = 5'd6;
	localparam logic [STEP_W-1:0] S_STRIP  = 5'd7;
	localparam logic [STEP_W-1:0] S_SDIV   = 5'd8;
	localparam logic [STEP_W-1:0] S_SDIV_W = 5'd9;
	localparam logic [STEP_W-1:0] S_STEST  = 5'd10;
	localparam logic [STEP_W-1:0] S_ADIV   = 5'd11;
	localparam logic [STEP_W-1:0] S_ADIV_W = 5'd12;
	localparam logic [STEP_W-1:0] S_ASUB   = 5'd13;
	localparam logic [STEP_W-1:0] S_NEXTP  = 5'd14;
	localparam logic [STEP_W-1:0] S_TAIL   = 5'd15;
	localparam logic [STEP_W-1:0] S_TDIV   = 5'd16;
	localparam logic [STEP_W-1:0] S_TDIV_W = 5'd17;
	localparam logic [STEP_W-1:0] S_TSUB   = 5'd18;
	localparam logic [STEP_W-1:0] S_ONE    = 5'd19;

	typedef struct packed {
		logic [1:0]        div_op;
		logic [2:0]        op;
		logic [3:0]        cond;
		logic [STEP_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [VALUE_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                   busy;
		logic [VALUE_WIDTH-1:0] quotient;
		logic [VALUE_WIDTH-1:0] remainder;
	} div_rsp_t;

	// control store: trial division factorization of n
	function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
		ctl_t w;
		begin
			case (step)
				S_OUT:    w = '{DIV_NONE,     OP_OUT,     C_OUT_FULL, S_OUT};
				S_IDLE:   w = '{DIV_NONE,     OP_LOAD,    C_NO_VALID, S_IDLE};
				S_CHECK:  w = '{DIV_NONE,     OP_NONE,    C_REST_LT2, S_ONE};
				S_TRY:    w = '{DIV_REST_P,   OP_NONE,    C_NEXT,     S_IDLE};
				S_TRY_W:  w = '{DIV_NONE,     OP_NONE,    C_BUSY,     S_TRY_W};
				S_TEST_Q: w = '{DIV_NONE,     OP_NONE,    C_Q_LT_P,   S_TAIL};
				S_TEST_R: w = '{DIV_NONE,     OP_NONE,    C_R_NZ,     S_NEXTP};
				S_STRIP:  w = '{DIV_NONE,     OP_REST_Q,  C_NEXT,     S_IDLE};
				S_SDIV:   w = '{DIV_REST_P,   OP_NONE,    C_NEXT,     S_IDLE};
				S_SDIV_W: w = '{DIV_NONE,     OP_NONE,    C_BUSY,     S_SDIV_W};
				S_STEST:  w = '{DIV_NONE,     OP_NONE,    C_R_Z,      S_STRIP};
				S_ADIV:   w = '{DIV_ACC_P,    OP_NONE,    C_NEXT,     S_IDLE};
				S_ADIV_W: w = '{DIV_NONE,     OP_NONE,    C_BUSY,     S_ADIV_W};
				S_ASUB:   w = '{DIV_NONE,     OP_ACC_SUB, C_NEXT,     S_IDLE};
				S_NEXTP:  w = '{DIV_NONE,     OP_P_INC,   C_ALWAYS,   S_TRY};
				S_TAIL:   w = '{DIV_NONE,     OP_NONE,    C_REST_LT2, S_OUT};
				S_TDIV:   w = '{DIV_ACC_REST, OP_NONE,    C_NEXT,     S_IDLE};
				S_TDIV_W: w = '{DIV_NONE,     OP_NONE,    C_BUSY,     S_TDIV_W};
				S_TSUB:   w = '{DIV_NONE,     OP_ACC_SUB, C_ALWAYS,   S_OUT};
				S_ONE:    w = '{DIV_NONE,     OP_ACC_ONE, C_ALWAYS,   S_OUT};
				default:  w = '{DIV_NONE,     OP_NONE,    C_ALWAYS,   S_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage

`default_nettype wire

### src/etc_div.sv
`default_nettype none

module etc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire etc_pkg::div_req_t req,
	output etc_pkg::div_rsp_t      rsp
);

	localparam int W = etc_pkg::VALUE_WIDTH;

	logic                          busy_q;
	logic [etc_pkg::CNT_W-1:0]     cnt_q;
	logic [W:0]                    rem_q;
	logic [W-1:0]                  quo_q;
	logic [W-1:0]                  dvs_q;
	logic [W:0]                    shifted;
	logic [W:0]                    diff;

	// one restoring step per cycle; quotient bits shift in behind the dividend
	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= etc_pkg::CNT_W'(W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q[W-1:0];

endmodule

`default_nettype wire

### src/euler_totient_count.sv
// Euler totient by trial-division factorization, run by a microcoded sequencer.
// One item at a time; every division waits on the single shared restoring divider.
// Output register lets the next word enter while a result waits for out_ready.
// Reset (arst_n low) sets the step counter to S_IDLE and clears the divider busy flag and output valid.
`default_nettype none

module euler_totient_count (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [etc_pkg::VALUE_WIDTH-1:0] number,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [etc_pkg::VALUE_WIDTH-1:0]      totient_value
);

	localparam int W = etc_pkg::VALUE_WIDTH;

	logic [etc_pkg::STEP_W-1:0] step_q;
	etc_pkg::ctl_t              uw;
	etc_pkg::div_req_t          dreq;
	etc_pkg::div_rsp_t          drsp;
	logic [W-1:0]               rest_q;
	logic [W-1:0]               acc_q;
	logic [W-1:0]               p_q;
	logic [W-1:0]               totient_q;
	logic                       out_valid_q;
	logic                       out_full;
	logic                       taken;

	assign uw       = etc_pkg::ucode(step_q);
	assign out_full = out_valid_q && !out_ready;
	assign in_ready = (uw.op == etc_pkg::OP_LOAD);

	always_comb begin
		case (uw.cond)
			etc_pkg::C_NEXT:     taken = 1'b0;
			etc_pkg::C_ALWAYS:   taken = 1'b1;
			etc_pkg::C_NO_VALID: taken = !in_valid;
			etc_pkg::C_REST_LT2: taken = (rest_q < W'(2));
			etc_pkg::C_BUSY:     taken = drsp.busy;
			etc_pkg::C_Q_LT_P:   taken = (drsp.quotient < p_q);
			etc_pkg::C_R_NZ:     taken = (drsp.remainder != '0);
			etc_pkg::C_R_Z:      taken = (drsp.remainder == '0);
			etc_pkg::C_OUT_FULL: taken = out_full;
			default:             taken = 1'b0;
		endcase
	end

	always_comb begin
		dreq.start    = (uw.div_op != etc_pkg::DIV_NONE);
		dreq.dividend = rest_q;
		dreq.divisor  = p_q;
		case (uw.div_op)
			etc_pkg::DIV_REST_P: begin
				dreq.dividend = rest_q;
				dreq.divisor  = p_q;
			end
			etc_pkg::DIV_ACC_P: begin
				dreq.dividend = acc_q;
				dreq.divisor  = p_q;
			end
			etc_pkg::DIV_ACC_REST: begin
				dreq.dividend = acc_q;
				dreq.divisor  = rest_q;
			end
			default: begin
				dreq.dividend = rest_q;
				dreq.divisor  = p_q;
			end
		endcase
	end

	etc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= etc_pkg::S_IDLE;
		end else if (taken) begin
			step_q <= uw.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (uw.op)
			etc_pkg::OP_LOAD: begin
				if (in_valid) begin
					rest_q <= number;
					acc_q  <= number;
					p_q    <= W'(2);
				end
			end
			etc_pkg::OP_REST_Q:  rest_q <= drsp.quotient;
			etc_pkg::OP_ACC_SUB: acc_q  <= acc_q - drsp.quotient;
			etc_pkg::OP_P_INC:   p_q    <= p_q + 1'b1;
			etc_pkg::OP_ACC_ONE: acc_q  <= W'(1);
			etc_pkg::OP_OUT: begin
				if (!out_full) begin
					totient_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	// hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == etc_pkg::OP_OUT && !out_full) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign totient_value = totient_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy)
		else $error("divider started while busy");

	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !drsp.busy)
		else $error("input taken while divider busy");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (totient_q != '0))
		else $error("zero totient issued");

	a_wait_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |=> drsp.busy)
		else $error("divider did not go busy");

	a_p_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == etc_pkg::S_TRY) |-> (p_q >= W'(2)))
		else $error("trial divisor below two");
`endif

endmodule

`default_nettype wire
